/* hdl/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, constants and helpers of the k-way run merger.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int MAX_RUNS    = 8;
    localparam int RUN_W       = $clog2(MAX_RUNS);
    localparam int CNT_W       = $clog2(MAX_RUNS + 1);
    localparam int RUN_IN_W    = 3;
    localparam int CMP_W       = (CNT_W > RUN_IN_W) ? CNT_W : RUN_IN_W;
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int CFG_RUNS_W  = 4;
    localparam int PAGE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNS_IN_USE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_PAGE = 2'd2;

    localparam logic                  DESCENDING_RESET = 1'b0;
    localparam logic [CFG_RUNS_W-1:0] RUNS_RESET       = 4'd8;
    localparam logic [PAGE_W-1:0]     ROWS_RESET       = 8'd250;
    localparam logic [PAGE_W:0]       PAGE_FULL        = 9'(1 << PAGE_W);

    typedef struct packed {
        logic [RUN_IN_W-1:0]     run;
        logic                    in_range;
        logic                    exhausted;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        row_tag;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic                    has_record;
        logic signed [KEY_W-1:0] key_res;
        logic [TAG_W-1:0]        row_tag_res;
        logic [RUN_IN_W-1:0]     source_run;
        logic                    page_end;
        logic                    merge_done;
    } t_res;

    function automatic logic [CNT_W-1:0] active_runs(input logic [CFG_RUNS_W-1:0] r);
        logic [CNT_W-1:0] n;
        if (r == '0) begin
            n = CNT_W'(1);
        end else if (r > MAX_RUNS) begin
            n = CNT_W'(MAX_RUNS);
        end else begin
            n = CNT_W'(r);
        end
        return n;
    endfunction

    function automatic logic [MAX_RUNS-1:0] run_mask(input logic [CFG_RUNS_W-1:0] r);
        logic [CNT_W-1:0]    n;
        logic [MAX_RUNS-1:0] m;
        n = active_runs(r);
        for (int i = 0; i < MAX_RUNS; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

/* hdl/kwm_in_if.sv */
// ----------------------------------------------------------------------------
// kwm_in_if
// Input channel: one beat refills or exhausts the head of one run.
// ----------------------------------------------------------------------------
interface kwm_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [kwm_pkg::RUN_IN_W-1:0]              run_index;
    logic                                      exhausted;
    logic signed [kwm_pkg::KEY_W-1:0]          key;
    logic [kwm_pkg::TAG_W-1:0]                 row_tag;

    modport source (output valid, run_index, exhausted, key, row_tag, input ready);
    modport sink   (input valid, run_index, exhausted, key, row_tag, output ready);
endinterface

/* hdl/kwm_out_if.sv */
// ----------------------------------------------------------------------------
// kwm_out_if
// Output channel: one beat carries a merged record or the done marker.
// ----------------------------------------------------------------------------
interface kwm_out_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      has_record;
    logic signed [kwm_pkg::KEY_W-1:0]          key_res;
    logic [kwm_pkg::TAG_W-1:0]                 row_tag_res;
    logic [kwm_pkg::RUN_IN_W-1:0]              source_run;
    logic                                      page_end;
    logic                                      merge_done;

    modport source (output valid, has_record, key_res, row_tag_res, source_run,
                    page_end, merge_done, input ready);
    modport sink   (input valid, has_record, key_res, row_tag_res, source_run,
                    page_end, merge_done, output ready);
endinterface

/* hdl/k_way_run_merger.sv */
// ----------------------------------------------------------------------------
// k_way_run_merger
// A result beat follows the input beat causing it through the queue write, then
// the back stage and output register.
// Throughput: one input beat per cycle unless the output stalls, set by the head
// update and the comparator tree over all run heads in the back stage.
// Reset (synchronous, active low): config to defaults, all heads invalid, all runs
// waiting, page count zero, queue and output register empty. No clearing pass.
// ----------------------------------------------------------------------------
module k_way_run_merger (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kwm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    kwm_in_if.sink                            i_in,
    kwm_out_if.source                         o_out
);

    logic                              r_descending;
    logic [kwm_pkg::CFG_RUNS_W-1:0]    r_runs_in_use;
    logic [kwm_pkg::PAGE_W-1:0]        r_rows_per_page;
    logic                              q_push;
    logic                              q_pop;
    kwm_pkg::t_cmd                     q_push_cmd;
    kwm_pkg::t_cmd                     q_head_cmd;
    kwm_pkg::t_q_stat                  q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending    <= kwm_pkg::DESCENDING_RESET;
            r_runs_in_use   <= kwm_pkg::RUNS_RESET;
            r_rows_per_page <= kwm_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kwm_pkg::CFG_DESCENDING: begin
                    r_descending <= i_cfg_data[0];
                end
                kwm_pkg::CFG_RUNS_IN_USE: begin
                    r_runs_in_use <= i_cfg_data[kwm_pkg::CFG_RUNS_W-1:0];
                end
                kwm_pkg::CFG_ROWS_PER_PAGE: begin
                    r_rows_per_page <= i_cfg_data[kwm_pkg::PAGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    kwm_front u_front (
        .i_in          (i_in),
        .i_runs_in_use (r_runs_in_use),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_push_cmd    (q_push_cmd)
    );

    kwm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .i_pop      (q_pop),
        .o_head_cmd (q_head_cmd),
        .o_stat     (q_stat)
    );

    kwm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_descending    (r_descending),
        .i_runs_in_use   (r_runs_in_use),
        .i_rows_per_page (r_rows_per_page),
        .i_q_stat        (q_stat),
        .i_head_cmd      (q_head_cmd),
        .o_pop           (q_pop),
        .o_out           (o_out)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_stat.full)
        else $error("input stalled with room in queue");

    a_done_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.merge_done) |-> !o_out.has_record)
        else $error("done beat carries a record");

    a_push_full_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.full && !q_pop) |=> q_stat.full)
        else $error("queue lost an entry");

endmodule

/* hdl/kwm_queue.sv */
// ----------------------------------------------------------------------------
// kwm_queue
// Short command queue between the front and the back of the merger.
// ----------------------------------------------------------------------------
module kwm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kwm_pkg::t_cmd    i_push_cmd,
    input  logic             i_pop,
    output kwm_pkg::t_cmd    o_head_cmd,
    output kwm_pkg::t_q_stat o_stat
);

    kwm_pkg::t_cmd                    r_mem [kwm_pkg::QUEUE_DEPTH];
    logic [kwm_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [kwm_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [kwm_pkg::QCNT_W-1:0]       r_count;
    logic [kwm_pkg::QCNT_W-1:0]       n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_head_cmd   = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == kwm_pkg::QCNT_W'(kwm_pkg::QUEUE_DEPTH));

endmodule

/* hdl/kwm_front.sv */
// ----------------------------------------------------------------------------
// kwm_front
// Accepts input beats and tags each with whether its run is in use.
// ----------------------------------------------------------------------------
module kwm_front (
    kwm_in_if.sink                            i_in,
    input  logic [kwm_pkg::CFG_RUNS_W-1:0]    i_runs_in_use,
    input  kwm_pkg::t_q_stat                  i_q_stat,
    output logic                              o_push,
    output kwm_pkg::t_cmd                     o_push_cmd
);

    logic [kwm_pkg::CNT_W-1:0] n_active;

    assign n_active    = kwm_pkg::active_runs(i_runs_in_use);
    assign i_in.ready  = !i_q_stat.full;
    assign o_push      = i_in.valid && !i_q_stat.full;

    assign o_push_cmd.run       = i_in.run_index;
    assign o_push_cmd.in_range  = (kwm_pkg::CMP_W'(i_in.run_index) <
                                   kwm_pkg::CMP_W'(n_active));
    assign o_push_cmd.exhausted = i_in.exhausted;
    assign o_push_cmd.key       = i_in.key;
    assign o_push_cmd.row_tag   = i_in.row_tag;

endmodule

/* hdl/kwm_back.sv */
// ----------------------------------------------------------------------------
// kwm_back
// Head registers, winner selection tree, page counter and output register.
// ----------------------------------------------------------------------------
module kwm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_descending,
    input  logic [kwm_pkg::CFG_RUNS_W-1:0]    i_runs_in_use,
    input  logic [kwm_pkg::PAGE_W-1:0]        i_rows_per_page,
    input  kwm_pkg::t_q_stat                  i_q_stat,
    input  kwm_pkg::t_cmd                     i_head_cmd,
    output logic                              o_pop,
    kwm_out_if.source                         o_out
);

    localparam int LEAVES = 1 << kwm_pkg::RUN_W;
    localparam int NODES  = 2 * LEAVES - 1;

    typedef struct packed {
        logic                             valid;
        logic signed [kwm_pkg::KEY_W-1:0] key;
        logic [kwm_pkg::TAG_W-1:0]        tag;
        logic [kwm_pkg::RUN_W-1:0]        idx;
    } t_node;

    function automatic t_node pick(input t_node a, input t_node b, input logic desc);
        logic b_first;
        b_first = desc ? ($signed(b.key) > $signed(a.key)) : ($signed(b.key) < $signed(a.key));
        return (b.valid && (!a.valid || b_first)) ? b : a;
    endfunction

    logic signed [kwm_pkg::KEY_W-1:0] r_key [kwm_pkg::MAX_RUNS];
    logic [kwm_pkg::TAG_W-1:0]        r_tag [kwm_pkg::MAX_RUNS];
    logic signed [kwm_pkg::KEY_W-1:0] n_key [kwm_pkg::MAX_RUNS];
    logic [kwm_pkg::TAG_W-1:0]        n_tag [kwm_pkg::MAX_RUNS];
    logic [kwm_pkg::MAX_RUNS-1:0]     r_valid;
    logic [kwm_pkg::MAX_RUNS-1:0]     r_waiting;
    logic [kwm_pkg::MAX_RUNS-1:0]     u_valid;
    logic [kwm_pkg::MAX_RUNS-1:0]     u_waiting;
    logic [kwm_pkg::MAX_RUNS-1:0]     n_valid;
    logic [kwm_pkg::MAX_RUNS-1:0]     n_waiting;
    logic [kwm_pkg::MAX_RUNS-1:0]     use_mask;
    logic [kwm_pkg::PAGE_W-1:0]       r_page_cnt;
    logic [kwm_pkg::PAGE_W-1:0]       n_page_cnt;
    logic [kwm_pkg::PAGE_W:0]         cnt_inc;
    logic [kwm_pkg::PAGE_W:0]         page_limit;
    logic                             r_out_valid;
    logic                             n_out_valid;
    kwm_pkg::t_res                    r_out;
    kwm_pkg::t_res                    n_res;
    logic [kwm_pkg::RUN_W-1:0]        slot;
    logic                             take;
    logic                             fire;
    logic                             any_wait;
    logic                             emit;
    t_node                            nd [NODES];

    assign use_mask = kwm_pkg::run_mask(i_runs_in_use);
    assign fire     = !i_q_stat.empty && (!r_out_valid || o_out.ready);
    assign o_pop    = fire;
    assign slot     = kwm_pkg::RUN_W'(i_head_cmd.run);
    assign take     = i_head_cmd.in_range && r_waiting[slot];

    // refill the addressed head
    always_comb begin
        n_key     = r_key;
        n_tag     = r_tag;
        u_valid   = r_valid;
        u_waiting = r_waiting;
        if (take) begin
            u_waiting[slot] = 1'b0;
            u_valid[slot]   = !i_head_cmd.exhausted;
            if (!i_head_cmd.exhausted) begin
                n_key[slot] = i_head_cmd.key;
                n_tag[slot] = i_head_cmd.row_tag;
            end
        end
    end

    assign any_wait = |(u_waiting & use_mask);
    assign emit     = fire && !any_wait;

    // selection tree, lower run wins ties
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < kwm_pkg::MAX_RUNS) begin : g_used
            assign nd[LEAVES - 1 + i] = '{valid: u_valid[i] & use_mask[i],
                                          key:   n_key[i],
                                          tag:   n_tag[i],
                                          idx:   kwm_pkg::RUN_W'(i)};
        end else begin : g_pad
            assign nd[LEAVES - 1 + i] = '0;
        end
    end
    for (genvar j = 0; j < LEAVES - 1; j++) begin : g_node
        assign nd[j] = pick(nd[2 * j + 1], nd[2 * j + 2], i_descending);
    end

    assign cnt_inc    = {1'b0, r_page_cnt} + 1'b1;
    assign page_limit = (i_rows_per_page == '0) ? kwm_pkg::PAGE_FULL : {1'b0, i_rows_per_page};

    always_comb begin
        n_valid    = u_valid;
        n_waiting  = u_waiting;
        n_page_cnt = r_page_cnt;
        n_res      = '0;
        if (nd[0].valid) begin
            n_res.has_record  = 1'b1;
            n_res.key_res     = nd[0].key;
            n_res.row_tag_res = nd[0].tag;
            n_res.source_run  = kwm_pkg::RUN_IN_W'(nd[0].idx);
            n_res.page_end    = (cnt_inc >= page_limit);
            n_page_cnt        = (cnt_inc >= page_limit) ? '0 : cnt_inc[kwm_pkg::PAGE_W-1:0];
            n_valid[nd[0].idx]   = 1'b0;
            n_waiting[nd[0].idx] = 1'b1;
        end else begin
            n_res.page_end   = (r_page_cnt != '0);
            n_res.merge_done = 1'b1;
            n_valid          = '0;
            n_waiting        = '1;
            n_page_cnt       = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_waiting   <= '1;
            r_page_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (emit) begin
                r_valid    <= n_valid;
                r_waiting  <= n_waiting;
                r_page_cnt <= n_page_cnt;
            end else if (fire) begin
                r_valid   <= u_valid;
                r_waiting <= u_waiting;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && take && !i_head_cmd.exhausted) begin
            r_key[slot] <= i_head_cmd.key;
            r_tag[slot] <= i_head_cmd.row_tag;
        end
        if (emit) begin
            r_out <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.has_record  = r_out.has_record;
    assign o_out.key_res     = r_out.key_res;
    assign o_out.row_tag_res = r_out.row_tag_res;
    assign o_out.source_run  = r_out.source_run;
    assign o_out.page_end    = r_out.page_end;
    assign o_out.merge_done  = r_out.merge_done;

endmodule
